/* rtl/core/ise_pkg.sv */
// ise_pkg: shared constants and controller/datapath interface types
// for the insertion sort engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ise_pkg;

    localparam int DEPTH = 16;
    localparam int VAL_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [VAL_W-1:0] value_t;
    typedef logic [CNT_W-1:0] count_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic insert;
        logic pop;
    } ise_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic one_left;
    } ise_status_t;

endpackage

`default_nettype wire

/* rtl/core/ise_datapath.sv */
// ise_datapath: sorted row of cells with parallel compare insert, fill count,
// drop flag and output word register. Depends on ise_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ise_pkg::ise_cmd_t   cmd,
    output ise_pkg::ise_status_t     status,
    input  wire ise_pkg::value_t     value,
    output ise_pkg::value_t          sorted_value,
    output logic                     final_res,
    output logic                     overflow
);

    ise_pkg::value_t cells_reg  [ise_pkg::DEPTH];
    ise_pkg::value_t cells_next [ise_pkg::DEPTH];
    ise_pkg::count_t fill_reg, fill_next;
    logic            dropped_reg, dropped_next;
    ise_pkg::value_t out_value_reg, out_value_next;
    logic            out_final_reg, out_final_next;
    logic            out_ovf_reg, out_ovf_next;

    logic [ise_pkg::DEPTH-1:0] gt;
    logic [ise_pkg::DEPTH-1:0] gt_below;

    // cells holding a larger value move up one place
    always_comb
    begin
        for (int i = 0; i < ise_pkg::DEPTH; i++)
        begin
            gt[i] = (ise_pkg::CNT_W'(i) < fill_reg) && (cells_reg[i] > value);
        end
        gt_below = {gt[ise_pkg::DEPTH-2:0], 1'b0};
    end

    always_comb
    begin
        cells_next     = cells_reg;
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;
        if (cmd.insert)
        begin
            if (fill_reg < ise_pkg::CNT_W'(ise_pkg::DEPTH))
            begin
                for (int i = 0; i < ise_pkg::DEPTH; i++)
                begin
                    if (ise_pkg::CNT_W'(i) <= fill_reg)
                    begin
                        if (gt_below[i])
                        begin
                            cells_next[i] = cells_reg[(i == 0) ? 0 : i - 1];
                        end
                        else if (gt[i] || (ise_pkg::CNT_W'(i) == fill_reg))
                        begin
                            cells_next[i] = value;
                        end
                    end
                end
                fill_next = fill_reg + ise_pkg::CNT_W'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < ise_pkg::DEPTH - 1; i++)
            begin
                cells_next[i] = cells_reg[i + 1];
            end
            fill_next      = fill_reg - ise_pkg::CNT_W'(1);
            out_value_next = cells_reg[0];
            out_final_next = (fill_reg == ise_pkg::CNT_W'(1));
            out_ovf_next   = dropped_reg;
            if (fill_reg == ise_pkg::CNT_W'(1))
            begin
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg     <= cells_next;
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign status.one_left = (fill_reg == ise_pkg::CNT_W'(1));
    assign sorted_value    = out_value_reg;
    assign final_res       = out_final_reg;
    assign overflow        = out_ovf_reg;

endmodule

`default_nettype wire

/* rtl/core/ise_ctrl.sv */
// ise_ctrl: fill/drain controller, input ready and output valid.
// Depends on ise_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ise_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ise_pkg::ise_cmd_t         cmd,
    input  wire ise_pkg::ise_status_t status
);

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_FILL:
            begin
                cmd.insert = in_valid;
                if (in_valid && last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // load the output word when it is empty or being taken
                if (!out_valid_reg || out_ready)
                begin
                    cmd.pop        = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.one_left)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_FILL);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/insertion_sort_engine.sv */
// insertion_sort_engine: top level, joins the controller and the datapath.
// Depends on ise_pkg, ise_ctrl, ise_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Sorts a run of unsigned 16-bit words into ascending order, duplicates kept.
// While filling, the engine takes one input word per cycle: every word is
// placed at once into a row of DEPTH cells that stays sorted, with all cells
// compared against the new word in parallel and the larger ones moved up one
// place (equal words keep arrival order). Words that arrive once the row is
// full are dropped and the run is flagged. A word with last set ends the run;
// the engine then stops taking input and drains the row from its low end, one
// result word per cycle through the output register while it is empty or
// being taken, each step shifting the cell row down one place. final_res
// marks the last result, and overflow is set on every result of a run that
// lost words. Input is taken again as soon as the last result is loaded,
// even while it still waits on out_ready.
module insertion_sort_engine (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input words
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [ise_pkg::VAL_W-1:0] value,
    input  wire logic                     last,
    // result words
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [ise_pkg::VAL_W-1:0]     sorted_value,
    output logic                          final_res,
    output logic                          overflow
);

    ise_pkg::ise_cmd_t    cmd;
    ise_pkg::ise_status_t status;

    // fill/drain sequencing and the handshakes
    ise_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // sorted cell row and output word register
    ise_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

/* rtl/core/ise_checker.sv */
// ise_checker: port-level assertions for insertion_sort_engine, with bind.
// Depends on ise_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module ise_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic [ise_pkg::VAL_W-1:0] value,
    input wire logic                      last,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [ise_pkg::VAL_W-1:0] sorted_value,
    input wire logic                      final_res,
    input wire logic                      overflow
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sorted_value)
            && $stable(final_res) && $stable(overflow))
        else $error("result word changed while stalled");

    // a last word closes the input for the drain
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("input taken right after last word");

    // a result word never carries unknown bits
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({sorted_value, final_res, overflow}))
        else $error("unknown bits on a result word");

    // a drain streams without gaps until the final result
    a_drain_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_res |=> out_valid)
        else $error("gap inside a sorted run");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (.*);

`default_nettype wire
